@@ rtl/core/prle_pkg.sv @@
`timescale 1ns / 1ps
// prle_pkg: shared constants, sequencer states and the beat structs that pass
// between the sequencer and the output stage of the packet RLE encoder.
// No dependencies.
package prle_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned WORD_W = 64;
	localparam int unsigned CNT_W  = 4;
	localparam int unsigned LEN_W  = 7;   // count field of a packet header
	localparam int unsigned PLEN_W = 8;   // packet size including its header
	localparam int unsigned CAP_W  = 16;
	localparam int unsigned DATA_W = 32;  // APB data
	localparam int unsigned ADDR_W = 3;   // APB byte address

	localparam logic [BYTE_W-1:0] RUN_FLAG    = 8'h80;
	localparam logic [LEN_W-1:0]  RUN_MIN     = 7'd3;
	localparam logic [PLEN_W-1:0] RUN_PKT_LEN = 8'd2;
	localparam logic [CAP_W-1:0]  CAP_RESET   = 16'hFFFF;

	// register index, taken from paddr above the byte offset
	localparam logic [ADDR_W-3:0] REG_OUT_CAPACITY = 1'b0;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FEED,
		ST_CLASS,
		ST_START,
		ST_FIN_RUN,
		ST_FIN_LA,
		ST_FIN_LIT,
		ST_CHK,
		ST_WORD,
		ST_DONE
	} seq_state_t;

	// sequencer to output stage
	typedef struct packed {
		logic              push;
		logic [WORD_W-1:0] word;
		logic [CNT_W-1:0]  cnt;
		logic              ovf;
		logic              flush;
		logic              frame_last;
	} emit_req_t;

	// output stage to sequencer
	typedef struct packed {
		logic can_push;
		logic can_flush;
		logic pend_v;
	} emit_stat_t;

endpackage

@@ rtl/core/prle_if.sv @@
`timescale 1ns / 1ps
// prle_if: valid/ready channels of the packet RLE encoder, one for raw bytes
// and one for encoded words. No dependencies.
interface prle_raw_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       frame_last;

	modport source (output valid, output data_byte, output frame_last, input ready);
	modport sink (input valid, input data_byte, input frame_last, output ready);
endinterface

interface prle_coded_if;
	logic        valid;
	logic        ready;
	logic [63:0] out_word;
	logic [3:0]  byte_count;
	logic        frame_end;
	logic        overflow;
	logic        burst_end;

	modport source (output valid, output out_word, output byte_count, output frame_end,
		output overflow, output burst_end, input ready);
	modport sink (input valid, input out_word, input byte_count, input frame_end,
		input overflow, input burst_end, output ready);
endinterface

@@ rtl/core/packet_rle_encoder_top.sv @@
`timescale 1ns / 1ps
// packet_rle_encoder_top: PackBits-style frame encoder with an APB capacity register.
// Steps: each byte is accepted, then classified; each settled packet adds a capacity check and
//   a drain of its words (16 at most), a reclassify follows a closed packet, frame end passes
//   the run, lookahead and literal steps, and a byte with results then flushes its burst end.
// Throughput: one byte at a time; one word out per cycle while coded.ready holds.
// Reset: arst_n clears all control state and sets out_capacity to 65535; no clearing pass.
module packet_rle_encoder_top
	import prle_pkg::*;
#(
	parameter int unsigned MAX_PACKET = 127,
	parameter int unsigned OUT_LANES  = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	prle_raw_if.sink          raw,
	prle_coded_if.source      coded
);

	logic [CAP_W-1:0] cap_q;
	logic             cfg_wr;
	emit_req_t        emit_req;
	emit_stat_t       emit_st;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	// write the capacity register; other indexes are ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_wr && paddr[ADDR_W-1:2] == REG_OUT_CAPACITY) begin
			cap_q <= pwdata[CAP_W-1:0];
		end
	end

	// read back the register value
	assign prdata = (paddr[ADDR_W-1:2] == REG_OUT_CAPACITY) ?
		{{(DATA_W - CAP_W){1'b0}}, cap_q} : '0;

	prle_seq #(
		.MAX_PACKET (MAX_PACKET),
		.OUT_LANES  (OUT_LANES)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.raw      (raw),
		.capacity (cap_q),
		.emit_req (emit_req),
		.emit_st  (emit_st)
	);

	prle_emit u_emit (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (emit_req),
		.st     (emit_st),
		.coded  (coded)
	);

endmodule

@@ rtl/core/prle_lit_mem.sv @@
`timescale 1ns / 1ps
// prle_lit_mem: literal store, one packet word per entry, byte-lane writes and
// one registered read port. Depends on prle_pkg.
module prle_lit_mem
	import prle_pkg::*;
#(
	parameter int unsigned DEPTH = 16,
	parameter int unsigned LANES = 8,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int unsigned LW = (LANES > 1) ? $clog2(LANES) : 1
) (
	input  logic                    clk,
	input  logic                    we,
	input  logic [AW-1:0]           waddr,
	input  logic [LW-1:0]           wlane,
	input  logic [BYTE_W-1:0]       wdata,
	input  logic [AW-1:0]           raddr,
	output logic [LANES*BYTE_W-1:0] rdata
);

	logic [LANES*BYTE_W-1:0] mem_q [DEPTH];
	logic [LANES*BYTE_W-1:0] rdata_q;

	// write one byte lane
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr][wlane*BYTE_W +: BYTE_W] <= wdata;
		end
	end

	// register the read word
	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/core/prle_emit.sv @@
`timescale 1ns / 1ps
// prle_emit: holds the newest result until the next one or the end of the
// byte shows whether it closes the burst, then drives the output register.
// Depends on prle_pkg and prle_if.
module prle_emit
	import prle_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  emit_req_t           req,
	output emit_stat_t          st,
	prle_coded_if.source        coded
);

	logic              pend_v_q;
	logic [WORD_W-1:0] pend_word_q;
	logic [CNT_W-1:0]  pend_cnt_q;
	logic              pend_ovf_q;

	logic              out_v_q;
	logic [WORD_W-1:0] out_word_q;
	logic [CNT_W-1:0]  out_cnt_q;
	logic              out_fend_q;
	logic              out_ovf_q;
	logic              out_bend_q;

	logic out_free;
	logic move_push;
	logic move_flush;
	logic load_out;

	assign out_free     = !out_v_q || coded.ready;
	assign st.can_push  = !pend_v_q || out_free;
	assign st.can_flush = out_free;
	assign st.pend_v    = pend_v_q;

	assign move_push  = req.push && st.can_push;
	assign move_flush = req.flush && out_free;
	assign load_out   = pend_v_q && (move_push || move_flush);

	// track pending and output occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (move_push) begin
				pend_v_q <= 1'b1;
			end else if (move_flush) begin
				pend_v_q <= 1'b0;
			end
			if (load_out) begin
				out_v_q <= 1'b1;
			end else if (coded.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	// advance the payload; a flush marks the burst end
	always_ff @(posedge clk) begin
		if (load_out) begin
			out_word_q <= pend_word_q;
			out_cnt_q  <= pend_cnt_q;
			out_ovf_q  <= pend_ovf_q;
			out_fend_q <= pend_ovf_q || (move_flush && req.frame_last);
			out_bend_q <= move_flush;
		end
		if (move_push) begin
			pend_word_q <= req.word;
			pend_cnt_q  <= req.cnt;
			pend_ovf_q  <= req.ovf;
		end
	end

	assign coded.valid      = out_v_q;
	assign coded.out_word   = out_word_q;
	assign coded.byte_count = out_cnt_q;
	assign coded.frame_end  = out_fend_q;
	assign coded.overflow   = out_ovf_q;
	assign coded.burst_end  = out_bend_q;

endmodule

@@ rtl/core/prle_seq.sv @@
`timescale 1ns / 1ps
// prle_seq: per-byte sequencer. Classifies bytes through the lookahead, keeps
// run state, fills the literal store and drains packets word by word.
// Depends on prle_pkg, prle_if and prle_lit_mem.
module prle_seq
	import prle_pkg::*;
#(
	parameter int unsigned MAX_PACKET = 127,
	parameter int unsigned OUT_LANES  = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	prle_raw_if.sink         raw,
	input  logic [CAP_W-1:0] capacity,
	output emit_req_t        emit_req,
	input  emit_stat_t       emit_st
);

	localparam int unsigned DEPTH      = (MAX_PACKET + OUT_LANES) / OUT_LANES;
	localparam int unsigned AW         = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned LW         = (OUT_LANES > 1) ? $clog2(OUT_LANES) : 1;
	localparam logic [AW-1:0]     FIRST_WORD = AW'(1 / OUT_LANES);
	localparam logic [LW-1:0]     FIRST_LANE = LW'(1 % OUT_LANES);
	localparam logic [LW-1:0]     LAST_LANE  = LW'(OUT_LANES - 1);
	localparam logic [LEN_W-1:0]  MAX_LEN    = LEN_W'(MAX_PACKET);
	localparam logic [PLEN_W-1:0] LANES_P    = PLEN_W'(OUT_LANES);
	localparam logic [CNT_W-1:0]  LANES_C    = CNT_W'(OUT_LANES);

	seq_state_t        state_q, state_d;
	seq_state_t        ret_q, ret_d;
	logic [BYTE_W-1:0] x_q, x_d;
	logic              last_q, last_d;
	logic [BYTE_W-1:0] la0_q, la0_d;
	logic [BYTE_W-1:0] la1_q, la1_d;
	logic [1:0]        fill_q, fill_d;
	logic [LEN_W-1:0]  lit_len_q, lit_len_d;
	logic [AW-1:0]     wr_word_q, wr_word_d;
	logic [LW-1:0]     wr_lane_q, wr_lane_d;
	logic [BYTE_W-1:0] rv_q, rv_d;
	logic [LEN_W-1:0]  rl_q, rl_d;
	logic              in_run_q, in_run_d;
	logic [CAP_W-1:0]  bw_q, bw_d;
	logic              ovf_q, ovf_d;
	logic              pk_run_q, pk_run_d;
	logic [AW-1:0]     rd_w_q, rd_w_d;
	logic [PLEN_W-1:0] bp_q, bp_d;
	logic [1:0]        fin_idx_q, fin_idx_d;

	logic                        mem_we;
	logic [BYTE_W-1:0]           lit_byte;
	logic [AW-1:0]               mem_raddr;
	logic [OUT_LANES*BYTE_W-1:0] mem_rdata;

	logic              run_class;
	logic              run_start;
	seq_state_t        lit_ret;
	seq_state_t        lit_next;
	seq_state_t        after_st;
	seq_state_t        ret_after;
	logic [BYTE_W-1:0] hdr;
	logic [PLEN_W-1:0] n_pkt;
	logic [PLEN_W-1:0] remaining;
	logic              last_w;
	logic [CNT_W-1:0]  cnt;
	logic [WORD_W-1:0] word;
	logic [CAP_W:0]    sum_bw;
	logic              over;

	prle_lit_mem #(
		.DEPTH (DEPTH),
		.LANES (OUT_LANES)
	) u_lit_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (wr_word_q),
		.wlane (wr_lane_q),
		.wdata (lit_byte),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	assign raw.ready = (state_q == ST_IDLE);

	// packet header, size and the capacity check
	assign hdr    = pk_run_q ? (RUN_FLAG | {1'b0, rl_q}) : {1'b0, lit_len_q};
	assign n_pkt  = pk_run_q ? RUN_PKT_LEN : ({1'b0, lit_len_q} + PLEN_W'(1));
	assign sum_bw = {1'b0, bw_q} + (CAP_W + 1)'(n_pkt);
	assign over   = sum_bw > {1'b0, capacity};

	assign after_st  = last_q ? ST_FIN_RUN : (emit_st.pend_v ? ST_DONE : ST_IDLE);
	assign ret_after = last_q ? ST_FIN_RUN : ST_DONE;

	// assemble the current packet word
	always_comb begin
		logic [PLEN_W-1:0] pos;
		logic [BYTE_W-1:0] lane;
		word      = '0;
		remaining = n_pkt - bp_q;
		last_w    = remaining <= LANES_P;
		cnt       = last_w ? remaining[CNT_W-1:0] : LANES_C;
		for (int k = 0; k < OUT_LANES; k++) begin
			pos = bp_q + PLEN_W'(k);
			if (pos == '0) begin
				lane = hdr;
			end else if (pk_run_q) begin
				lane = (pos == PLEN_W'(1)) ? rv_q : '0;
			end else begin
				lane = mem_rdata[k*BYTE_W +: BYTE_W];
			end
			if (PLEN_W'(k) < remaining) begin
				word[k*BYTE_W +: BYTE_W] = lane;
			end
		end
	end

	// next state and outputs
	always_comb begin
		state_d   = state_q;
		ret_d     = ret_q;
		x_d       = x_q;
		last_d    = last_q;
		la0_d     = la0_q;
		la1_d     = la1_q;
		fill_d    = fill_q;
		lit_len_d = lit_len_q;
		wr_word_d = wr_word_q;
		wr_lane_d = wr_lane_q;
		rv_d      = rv_q;
		rl_d      = rl_q;
		in_run_d  = in_run_q;
		bw_d      = bw_q;
		ovf_d     = ovf_q;
		pk_run_d  = pk_run_q;
		rd_w_d    = rd_w_q;
		bp_d      = bp_q;
		fin_idx_d = fin_idx_q;

		mem_we    = 1'b0;
		lit_byte  = la0_q;
		mem_raddr = rd_w_q;
		run_class = 1'b0;
		run_start = 1'b0;
		lit_ret   = ret_after;
		lit_next  = after_st;
		emit_req  = '0;
		emit_req.frame_last = last_q;

		case (state_q)
			ST_IDLE: begin
				if (raw.valid) begin
					x_d    = raw.data_byte;
					last_d = raw.frame_last;
					if (!ovf_q) begin
						state_d = ST_FEED;
					end else if (raw.frame_last) begin
						// aborted frame ends here without a result
						ovf_d     = 1'b0;
						fill_d    = '0;
						lit_len_d = '0;
						wr_word_d = FIRST_WORD;
						wr_lane_d = FIRST_LANE;
						rl_d      = '0;
						in_run_d  = 1'b0;
						bw_d      = '0;
					end
				end
			end
			ST_FEED: begin
				if (in_run_q && x_q == rv_q && rl_q < MAX_LEN) begin
					rl_d = rl_q + LEN_W'(1);
					if (rl_q == MAX_LEN - LEN_W'(1)) begin
						pk_run_d = 1'b1;
						ret_d    = ret_after;
						state_d  = ST_CHK;
					end else begin
						state_d = after_st;
					end
				end else if (in_run_q) begin
					// close the run, then classify the byte
					pk_run_d = 1'b1;
					ret_d    = ST_CLASS;
					state_d  = ST_CHK;
				end else begin
					run_class = 1'b1;
				end
			end
			ST_CLASS: begin
				run_class = 1'b1;
			end
			ST_START: begin
				run_start = 1'b1;
			end
			ST_FIN_RUN: begin
				fin_idx_d = '0;
				if (in_run_q) begin
					pk_run_d = 1'b1;
					ret_d    = ST_FIN_LA;
					state_d  = ST_CHK;
				end else begin
					state_d = ST_FIN_LA;
				end
			end
			ST_FIN_LA: begin
				if (fin_idx_q < fill_q) begin
					mem_we    = 1'b1;
					lit_byte  = fin_idx_q[0] ? la1_q : la0_q;
					fin_idx_d = fin_idx_q + 2'd1;
					lit_ret   = ST_FIN_LA;
					lit_next  = ST_FIN_LA;
				end else begin
					state_d = ST_FIN_LIT;
				end
			end
			ST_FIN_LIT: begin
				if (lit_len_q != '0) begin
					pk_run_d = 1'b0;
					ret_d    = ST_DONE;
					state_d  = ST_CHK;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_CHK: begin
				mem_raddr = '0;
				if (over) begin
					if (emit_st.can_push) begin
						// abort the frame with one overflow result
						emit_req.push = 1'b1;
						emit_req.ovf  = 1'b1;
						ovf_d     = 1'b1;
						fill_d    = '0;
						lit_len_d = '0;
						wr_word_d = FIRST_WORD;
						wr_lane_d = FIRST_LANE;
						rl_d      = '0;
						in_run_d  = 1'b0;
						bw_d      = '0;
						state_d   = ST_DONE;
					end
				end else begin
					bw_d    = sum_bw[CAP_W-1:0];
					bp_d    = '0;
					rd_w_d  = '0;
					state_d = ST_WORD;
				end
			end
			ST_WORD: begin
				if (emit_st.can_push) begin
					emit_req.push = 1'b1;
					emit_req.word = word;
					emit_req.cnt  = cnt;
					if (last_w) begin
						if (pk_run_q) begin
							in_run_d = 1'b0;
							rl_d     = '0;
						end else begin
							lit_len_d = '0;
							wr_word_d = FIRST_WORD;
							wr_lane_d = FIRST_LANE;
						end
						state_d = ret_q;
					end else begin
						bp_d      = bp_q + LANES_P;
						rd_w_d    = rd_w_q + AW'(1);
						mem_raddr = rd_w_q + AW'(1);
					end
				end
			end
			ST_DONE: begin
				if (!emit_st.pend_v || emit_st.can_flush) begin
					emit_req.flush = 1'b1;
					if (last_q) begin
						ovf_d     = 1'b0;
						fill_d    = '0;
						lit_len_d = '0;
						wr_word_d = FIRST_WORD;
						wr_lane_d = FIRST_LANE;
						rl_d      = '0;
						in_run_d  = 1'b0;
						bw_d      = '0;
					end
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase

		// classify a byte against the two lookahead bytes
		if (run_class) begin
			if (fill_q != 2'd2) begin
				if (fill_q == 2'd0) begin
					la0_d = x_q;
				end else begin
					la1_d = x_q;
				end
				fill_d  = fill_q + 2'd1;
				state_d = after_st;
			end else if (la0_q == la1_q && la1_q == x_q) begin
				if (lit_len_q != '0) begin
					pk_run_d = 1'b0;
					ret_d    = ST_START;
					state_d  = ST_CHK;
				end else begin
					run_start = 1'b1;
				end
			end else begin
				mem_we   = 1'b1;
				lit_byte = la0_q;
				la0_d    = la1_q;
				la1_d    = x_q;
			end
		end

		// open a run of three
		if (run_start) begin
			in_run_d = 1'b1;
			rv_d     = x_q;
			rl_d     = RUN_MIN;
			fill_d   = '0;
			if (RUN_MIN >= MAX_LEN) begin
				pk_run_d = 1'b1;
				ret_d    = ret_after;
				state_d  = ST_CHK;
			end else begin
				state_d = after_st;
			end
		end

		// append to the literal store, settle when full
		if (mem_we) begin
			lit_len_d = lit_len_q + LEN_W'(1);
			if (wr_lane_q == LAST_LANE) begin
				wr_lane_d = '0;
				wr_word_d = wr_word_q + AW'(1);
			end else begin
				wr_lane_d = wr_lane_q + LW'(1);
			end
			if (lit_len_q == MAX_LEN - LEN_W'(1)) begin
				pk_run_d = 1'b0;
				ret_d    = lit_ret;
				state_d  = ST_CHK;
			end else begin
				state_d = lit_next;
			end
		end
	end

	// hold sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			ret_q     <= ST_IDLE;
			x_q       <= '0;
			last_q    <= 1'b0;
			la0_q     <= '0;
			la1_q     <= '0;
			fill_q    <= '0;
			lit_len_q <= '0;
			wr_word_q <= FIRST_WORD;
			wr_lane_q <= FIRST_LANE;
			rv_q      <= '0;
			rl_q      <= '0;
			in_run_q  <= 1'b0;
			bw_q      <= '0;
			ovf_q     <= 1'b0;
			pk_run_q  <= 1'b0;
			rd_w_q    <= '0;
			bp_q      <= '0;
			fin_idx_q <= '0;
		end else begin
			state_q   <= state_d;
			ret_q     <= ret_d;
			x_q       <= x_d;
			last_q    <= last_d;
			la0_q     <= la0_d;
			la1_q     <= la1_d;
			fill_q    <= fill_d;
			lit_len_q <= lit_len_d;
			wr_word_q <= wr_word_d;
			wr_lane_q <= wr_lane_d;
			rv_q      <= rv_d;
			rl_q      <= rl_d;
			in_run_q  <= in_run_d;
			bw_q      <= bw_d;
			ovf_q     <= ovf_d;
			pk_run_q  <= pk_run_d;
			rd_w_q    <= rd_w_d;
			bp_q      <= bp_d;
			fin_idx_q <= fin_idx_d;
		end
	end

	// a run never coexists with lookahead bytes or an open literal
	a_run_alone: assert property (@(posedge clk) disable iff (!arst_n)
		in_run_q |-> (fill_q == 2'd0 && lit_len_q == '0))
		else $error("run open with lookahead or literal bytes held");

	// results are only offered when the output stage can take them
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		emit_req.push |-> emit_st.can_push)
		else $error("result pushed into a full output stage");

	// every byte leaves its results fully handed off before the next one
	a_idle_drained: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !emit_st.pend_v)
		else $error("pending result left behind at idle");

	// packet counts stay within the header range
	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(lit_len_q <= MAX_LEN) && (rl_q <= MAX_LEN))
		else $error("packet count beyond the maximum");

	// a drained word always carries bytes
	a_word_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_WORD |-> (cnt != '0 && cnt <= LANES_C))
		else $error("empty or oversized packet word");

endmodule
